### sv/dmrt_pkg.sv
// ----------------------------------------------------------------------------
// dmrt_pkg: shared types and constants
// Slot layout, operation codes and the fixed widths of the result table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmrt_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 13;
  localparam int FUNC_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [CFG_W-1:0]   CFG_RESET = 13'd4096;

  localparam int TABLE_SLOTS_DEF = 4096;
  localparam int DEPTH_LIMIT     = 128;
  // stored depth never goes above DEPTH_LIMIT-1 nor above the 7-bit range
  localparam int DEPTH_CAP_I = (DEPTH_LIMIT - 1 > 127) ? 127 : DEPTH_LIMIT - 1;
  localparam logic [6:0] DEPTH_CAP = 7'(DEPTH_CAP_I);

  // modulo unit: key bits retired per cycle
  localparam int MOD_BITS   = 4;
  localparam int MOD_STEPS  = KEY_W / MOD_BITS;
  localparam int DIV_CNT_W  = $clog2(MOD_STEPS);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_PROBE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_PROBE,
    OP_STORE,
    OP_CLEAR
  } op_t;

  localparam int OP_W = $bits(op_t);

  typedef struct packed {
    logic [1:0]         flags;
    logic [6:0]         depth;
    logic signed [15:0] score;
    logic [31:0]        move;
  } payload_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    payload_t         pay;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_HOLD
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_LOOK,
    BK_CLEAR,
    BK_ZOUT
  } bk_state_t;

endpackage

`default_nettype wire

### sv/dmrt_ram.sv
// ----------------------------------------------------------------------------
// dmrt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/dmrt_queue.sv
// ----------------------------------------------------------------------------
// dmrt_queue: short word queue between front and back
// Small register FIFO; pointers wrap at the depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrt_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  import dmrt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] words_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = words_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wptr_r + 1'b1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      words_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### sv/dmrt_front.sv
// ----------------------------------------------------------------------------
// dmrt_front: input stage
// Accepts a word, decodes the operation, clamps the depth and reduces the
// key modulo the active slot count for probes and stores, four key bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrt_front #(
  parameter int TABLE_SLOTS = dmrt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [dmrt_pkg::CFG_W-1:0] cfg_entries,
  input  wire logic                       init_busy,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_func,
  input  wire logic [63:0]                in_key,
  input  wire logic [1:0]                 in_flag_bits,
  input  wire logic [6:0]                 in_search_depth,
  input  wire logic signed [15:0]         in_score,
  input  wire logic [31:0]                in_best_move,
  output logic                            q_push,
  output logic [dmrt_pkg::OP_W + $clog2(TABLE_SLOTS) + dmrt_pkg::SLOT_W - 1:0] q_wdata,
  input  wire logic                       q_full
);
  import dmrt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int N_W   = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W = (N_W > CFG_W) ? N_W : CFG_W;

  fe_state_t              state_r, state_nxt;
  op_t                    op_r, op_dec;
  slot_t                  slot_r;
  logic [N_W-1:0]         n_r;
  logic [IDX_W-1:0]       rem_r, rem_step;
  logic [KEY_W-1:0]       shift_r, shift_step;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [CMP_W-1:0]       cfg_ext, eff_wide;
  logic [6:0]             depth_sat;
  logic                   accept;

  assign in_full = (state_r != FE_IDLE) || init_busy;
  assign accept  = in_push && !in_full;
  assign q_push  = (state_r == FE_HOLD);
  assign q_wdata = {op_r, rem_r, slot_r};

  // zero or oversized counts fall back to the full table
  assign cfg_ext  = CMP_W'(cfg_entries);
  assign eff_wide = (cfg_ext == '0 || cfg_ext > CMP_W'(TABLE_SLOTS)) ?
                    CMP_W'(TABLE_SLOTS) : cfg_ext;
  assign depth_sat = (in_search_depth > DEPTH_CAP) ? DEPTH_CAP : in_search_depth;

  always_comb begin
    unique case (in_func) inside
      FUNC_STORE:              op_dec = OP_STORE;
      FUNC_CLEAR:              op_dec = OP_CLEAR;
      FUNC_PROBE, FUNC_UNUSED: op_dec = OP_PROBE;
      default:                 op_dec = OP_PROBE;
    endcase
  end

  // restoring remainder, MOD_BITS steps a cycle
  always_comb begin
    logic [IDX_W:0] t;
    logic [IDX_W:0] n_ext;
    n_ext      = (IDX_W + 1)'(n_r);
    rem_step   = rem_r;
    shift_step = shift_r;
    for (int i = 0; i < MOD_BITS; i++) begin
      t          = {rem_step, shift_step[KEY_W-1]};
      shift_step = {shift_step[KEY_W-2:0], 1'b0};
      if (t >= n_ext) begin
        rem_step = IDX_W'(t - n_ext);
      end else begin
        rem_step = t[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: begin
        if (accept) begin
          state_nxt = (op_dec == OP_CLEAR) ? FE_HOLD : FE_DIV;
        end
      end
      FE_DIV: begin
        if (cnt_r == DIV_CNT_W'(MOD_STEPS - 1)) begin
          state_nxt = FE_HOLD;
        end
      end
      FE_HOLD: begin
        if (!q_full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == FE_DIV) begin
        cnt_r <= DIV_CNT_W'(cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r            <= op_dec;
      n_r             <= N_W'(eff_wide);
      rem_r           <= '0;
      shift_r         <= in_key;
      slot_r.key      <= in_key;
      slot_r.pay      <= '{flags: in_flag_bits, depth: depth_sat,
                           score: in_score, move: in_best_move};
    end else if (state_r == FE_DIV) begin
      rem_r   <= rem_step;
      shift_r <= shift_step;
    end
  end

endmodule

`default_nettype wire

### sv/dmrt_back.sv
// ----------------------------------------------------------------------------
// dmrt_back: table stage
// Owns the slot RAM and occupied count, runs a RAM read per probe and a
// read-modify-write per store, sweeps the RAM on reset and clear, holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrt_back #(
  parameter int TABLE_SLOTS = dmrt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  output logic                              init_busy,
  input  wire logic                         q_empty,
  input  wire logic [dmrt_pkg::OP_W + $clog2(TABLE_SLOTS) + dmrt_pkg::SLOT_W - 1:0] q_rdata,
  output logic                              q_pop,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output dmrt_pkg::slot_t                   out_slot,
  output logic [dmrt_pkg::COUNT_W-1:0]      out_count
);
  import dmrt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int Q_W   = OP_W + IDX_W + SLOT_W;

  bk_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]    sweep_r, sweep_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  op_t                 cur_op_r, hd_op;
  logic [IDX_W-1:0]    cur_idx_r, hd_idx;
  slot_t               cur_slot_r, hd_slot, rd_slot, load_slot;
  logic [COUNT_W-1:0]  load_count;
  logic                take, load, out_free;
  logic                out_valid_r;
  slot_t               out_slot_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  slot_t               ram_wdata;
  logic [SLOT_W-1:0]   ram_rdata;

  assign hd_op   = op_t'(q_rdata[Q_W-1 -: OP_W]);
  assign hd_idx  = q_rdata[SLOT_W +: IDX_W];
  assign hd_slot = slot_t'(q_rdata[SLOT_W-1:0]);
  assign rd_slot = slot_t'(ram_rdata);

  assign init_busy = (state_r == BK_INIT);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_count = out_count_r;

  dmrt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (hd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    sweep_nxt  = sweep_r;
    count_nxt  = count_r;
    q_pop      = 1'b0;
    take       = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = sweep_r;
    ram_wdata  = '0;
    load       = 1'b0;
    load_slot  = rd_slot;
    load_count = count_r;
    unique case (state_r)
      BK_INIT, BK_CLEAR: begin
        ram_we    = 1'b1;
        sweep_nxt = IDX_W'(sweep_r + 1'b1);
        if (sweep_r == IDX_W'(TABLE_SLOTS - 1)) begin
          sweep_nxt = '0;
          state_nxt = (state_r == BK_INIT) ? BK_IDLE : BK_ZOUT;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          take  = 1'b1;
          if (hd_op == OP_CLEAR) begin
            count_nxt = '0;
            sweep_nxt = '0;
            state_nxt = BK_CLEAR;
          end else begin
            ram_re    = 1'b1;
            state_nxt = BK_LOOK;
          end
        end
      end
      BK_LOOK: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
          if (cur_op_r == OP_STORE) begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx_r;
            ram_wdata = cur_slot_r;
            load_slot = cur_slot_r;
            if (rd_slot.key == '0 && count_r != COUNT_MAX) begin
              count_nxt = COUNT_W'(count_r + 1'b1);
            end
            load_count = count_nxt;
          end
        end
      end
      BK_ZOUT: begin
        if (out_free) begin
          load       = 1'b1;
          load_slot  = '0;
          load_count = '0;
          state_nxt  = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_op_r   <= hd_op;
      cur_idx_r  <= hd_idx;
      cur_slot_r <= hd_slot;
    end
    if (load) begin
      out_slot_r  <= load_slot;
      out_count_r <= load_count;
    end
  end

endmodule

`default_nettype wire

### sv/direct_mapped_result_table.sv
// ----------------------------------------------------------------------------
// direct_mapped_result_table: direct-mapped, always-replace result table
// Probe, store and clear-all on a key-indexed slot table with occupied count.
// ----------------------------------------------------------------------------
// Flow: a probe or store result word goes through the modulo steps, the queue
//   hand-off, the RAM read and then the RAM write/result load before it shows.
// Requests: the front takes a new probe or store only once the queue has taken
//   the last one, whose key it reduces 4 key bits per cycle; a clear occupies the
//   back for a RAM sweep over all TABLE_SLOTS entries and the zero result load.
// Reset: synchronous; the back sweeps all TABLE_SLOTS RAM entries to zero
//   with in_full held high; cfg writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_result_table #(
  parameter int TABLE_SLOTS = dmrt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration word: active slot count
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [dmrt_pkg::CFG_W-1:0] cfg_entries_in_use,
  // request words
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_func,
  input  wire logic [63:0]                in_key,
  input  wire logic [1:0]                 in_flag_bits,
  input  wire logic [6:0]                 in_search_depth,
  input  wire logic signed [15:0]         in_score,
  input  wire logic [31:0]                in_best_move,
  // result words
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [63:0]                     out_slot_key,
  output logic [1:0]                      out_slot_flags,
  output logic [6:0]                      out_slot_depth,
  output logic signed [15:0]              out_slot_score,
  output logic [31:0]                     out_slot_move,
  output logic [dmrt_pkg::COUNT_W-1:0]    out_occupied_count
);
  import dmrt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int Q_W   = OP_W + IDX_W + SLOT_W;

  logic [CFG_W-1:0] cfg_entries_r;
  logic             init_busy;
  logic             q_push, q_full, q_pop, q_empty;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  slot_t            res_slot;

  // the user must rewrite this register only while idle; the block does not enforce it, so no handshake back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cfg_entries_r <= cfg_entries_in_use;
    end
  end

  // front: decode, depth clamp, key mod slot count
  dmrt_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_entries     (cfg_entries_r),
    .init_busy       (init_busy),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_flag_bits    (in_flag_bits),
    .in_search_depth (in_search_depth),
    .in_score        (in_score),
    .in_best_move    (in_best_move),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  // decoupling queue: the front can take the next word while the back
  // is busy with a RAM access or a clear sweep
  dmrt_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: slot RAM read-modify-write, count, clears, result register
  dmrt_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_slot  (res_slot),
    .out_count (out_occupied_count)
  );

  assign out_slot_key   = res_slot.key;
  assign out_slot_flags = res_slot.pay.flags;
  assign out_slot_depth = res_slot.pay.depth;
  assign out_slot_score = res_slot.pay.score;
  assign out_slot_move  = res_slot.pay.move;

endmodule

`default_nettype wire

### sv/dmrt_checker.sv
// ----------------------------------------------------------------------------
// dmrt_checker: port-level checks for the result table
// Reset behavior, result hold and empty-table consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic [63:0]        out_slot_key,
  input wire logic [1:0]         out_slot_flags,
  input wire logic [6:0]         out_slot_depth,
  input wire logic signed [15:0] out_slot_score,
  input wire logic [31:0]        out_slot_move,
  input wire logic [12:0]        out_occupied_count
);

  // reset drops any pending result and starts the clearing sweep
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("request accepted during reset sweep");

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_slot_key) && $stable(out_slot_move) &&
       $stable(out_occupied_count)))
    else $error("result changed before pop");

  // nothing stored since clear or reset: every slot still reads empty
  a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_occupied_count == 13'd0) |->
      (out_slot_key == 64'd0 && out_slot_move == 32'd0 &&
       out_slot_flags == 2'd0 && out_slot_depth == 7'd0 &&
       out_slot_score == 16'sd0))
    else $error("non-empty slot with zero occupied count");

endmodule

bind direct_mapped_result_table dmrt_checker u_dmrt_checker (.*);

`default_nettype wire
